@@ rtl/core/slt_pkg.sv @@
package slt_pkg;

    // Longest token kept; bytes beyond it are dropped and flagged
    localparam logic [7:0] MAX_TOKEN = 8'd255;

    // Escape tracking codes
    localparam logic [1:0] ESC_NONE = 2'd0;  // no escape pending
    localparam logic [1:0] ESC_BSL  = 2'd1;  // after backslash
    localparam logic [1:0] ESC_X    = 2'd2;  // after \x
    localparam logic [1:0] ESC_H1   = 2'd3;  // after first hex character

    // Characters of interest
    localparam logic [7:0] CH_DELIM_LIM = 8'h21;  // '!': anything below is a delimiter
    localparam logic [7:0] CH_BSL       = 8'h5C;
    localparam logic [7:0] CH_QUOTE     = 8'h22;
    localparam logic [7:0] CH_N         = 8'h6E;
    localparam logic [7:0] CH_R         = 8'h72;
    localparam logic [7:0] CH_T         = 8'h74;
    localparam logic [7:0] CH_ZERO      = 8'h30;
    localparam logic [7:0] CH_X         = 8'h78;

    // Token heads that open string mode (first byte in low lane)
    localparam logic [31:0] HEAD_DOT_QUOTE = 32'h0000_222E;  // ."
    localparam logic [31:0] HEAD_S_QUOTE   = 32'h0000_2273;  // s"
    localparam logic [31:0] HEAD_DT_QUOTE  = 32'h2254_442E;  // .DT"

    // One result item
    typedef struct packed {
        logic [7:0] token_byte;
        logic       byte_valid;
        logic       token_end;
        logic       quoted;
        logic       overflow;
        logic       bad_hex;
    } t_result;

    // Outcome of a \x escape
    typedef struct packed {
        logic       ok;
        logic [7:0] value;
    } t_hex;

    function automatic logic is_hex(input logic [7:0] c);
        return (c inside {[8'h30:8'h39], [8'h61:8'h66], [8'h41:8'h46]});
    endfunction

    function automatic logic [3:0] hex_val(input logic [7:0] c);
        logic [7:0] d;
        if (c inside {[8'h30:8'h39]}) begin
            d = c - 8'h30;
        end else if (c inside {[8'h61:8'h66]}) begin
            d = c - 8'h57;
        end else begin
            d = c - 8'h37;
        end
        return d[3:0];
    endfunction

    // One or two hex digits; a non-hex second character leaves the first alone
    function automatic t_hex resolve_hex(input logic [7:0] first, input logic [7:0] second);
        t_hex r;
        r.ok    = is_hex(first);
        r.value = is_hex(second) ? {hex_val(first), hex_val(second)}
                                 : {4'b0000, hex_val(first)};
        if (!r.ok) begin
            r.value = 8'h00;
        end
        return r;
    endfunction

    // Single-character escapes
    function automatic logic [7:0] escape_byte(input logic [7:0] c);
        logic [7:0] b;
        case (c)
            CH_N:    b = 8'h0A;
            CH_R:    b = 8'h0D;
            CH_T:    b = 8'h09;
            CH_ZERO: b = 8'h00;
            default: b = c;
        endcase
        return b;
    endfunction

endpackage

@@ rtl/core/slt_engine.sv @@
module slt_engine (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_fire,        // held character is consumed this cycle
    input  logic [7:0]       i_ch,
    input  logic             i_line_end,
    output logic             o_res_valid,   // character produces a result item
    output slt_pkg::t_result o_res
);
    import slt_pkg::*;

    // Tokenizer state
    logic        r_string_mode, n_string_mode;
    logic [1:0]  r_esc,         n_esc;
    logic [7:0]  r_hex_first,   n_hex_first;
    logic        r_skip,        n_skip;
    logic [7:0]  r_len,         n_len;
    logic [31:0] r_head,        n_head;

    logic        have_b;
    logic [7:0]  b;
    logic        tend;
    logic        quoted;
    logic        bad;
    logic        ovf;
    logic        valid;
    logic        clr_tok;
    logic        opens;
    logic [7:0]  len_cur;
    logic [31:0] head_cur;
    t_hex        hx;

    // String-mode trigger on the token as it stands
    assign opens = ((r_len == 8'd2) && ((r_head == HEAD_DOT_QUOTE) || (r_head == HEAD_S_QUOTE)))
                || ((r_len == 8'd4) && (r_head == HEAD_DT_QUOTE));

    // Per-character decode, append and flush
    always_comb begin
        n_string_mode = r_string_mode;
        n_esc         = r_esc;
        n_hex_first   = r_hex_first;
        n_skip        = r_skip;
        have_b        = 1'b0;
        b             = 8'h00;
        tend          = 1'b0;
        quoted        = 1'b0;
        bad           = 1'b0;
        ovf           = 1'b0;
        valid         = 1'b0;
        clr_tok       = 1'b0;
        hx            = '0;

        if (r_skip) begin
            n_skip = 1'b0;
        end else if (r_esc == ESC_BSL) begin
            if (i_ch == CH_X) begin
                n_esc = ESC_X;
            end else begin
                n_esc  = ESC_NONE;
                have_b = 1'b1;
                b      = escape_byte(i_ch);
            end
        end else if (r_esc == ESC_X) begin
            n_hex_first = i_ch;
            n_esc       = ESC_H1;
        end else if (r_esc == ESC_H1) begin
            n_esc  = ESC_NONE;
            hx     = resolve_hex(r_hex_first, i_ch);
            have_b = hx.ok;
            b      = hx.value;
            bad    = !hx.ok;
        end else if (r_string_mode) begin
            if (i_ch == CH_BSL) begin
                n_esc = ESC_BSL;
            end else if (i_ch == CH_QUOTE) begin
                have_b        = 1'b1;
                b             = i_ch;
                tend          = 1'b1;
                quoted        = 1'b1;
                n_string_mode = 1'b0;
                n_skip        = 1'b1;
            end else begin
                have_b = 1'b1;
                b      = i_ch;
            end
        end else if (i_ch < CH_DELIM_LIM) begin
            if (r_len != 8'd0) begin
                tend    = 1'b1;
                clr_tok = 1'b1;
                if (opens) begin
                    n_string_mode = 1'b1;
                end
            end
        end else begin
            have_b = 1'b1;
            b      = i_ch;
        end

        // Line end inside an escape
        if (i_line_end) begin
            if (n_esc == ESC_X) begin
                bad = 1'b1;
            end else if (n_esc == ESC_H1) begin
                hx     = resolve_hex(n_hex_first, 8'h00);
                have_b = hx.ok;
                b      = hx.value;
                bad    = !hx.ok;
            end
        end

        // Append to the token, saturating at MAX_TOKEN
        len_cur  = clr_tok ? 8'd0  : r_len;
        head_cur = clr_tok ? 32'd0 : r_head;
        n_len    = len_cur;
        n_head   = head_cur;
        if (have_b) begin
            if (len_cur < MAX_TOKEN) begin
                if (len_cur < 8'd4) begin
                    n_head = head_cur | ({24'd0, b} << {len_cur[1:0], 3'b000});
                end
                n_len = len_cur + 8'd1;
                valid = 1'b1;
            end else begin
                ovf = 1'b1;
            end
        end

        if (quoted) begin
            n_len  = 8'd0;
            n_head = 32'd0;
        end

        // Line end flushes and returns everything to reset
        if (i_line_end) begin
            if (n_len != 8'd0) begin
                tend = 1'b1;
            end
            n_string_mode = 1'b0;
            n_esc         = ESC_NONE;
            n_hex_first   = 8'h00;
            n_skip        = 1'b0;
            n_len         = 8'd0;
            n_head        = 32'd0;
        end
    end

    assign o_res_valid       = valid | tend | ovf | bad;
    assign o_res.token_byte  = valid ? b : 8'h00;
    assign o_res.byte_valid  = valid;
    assign o_res.token_end   = tend;
    assign o_res.quoted      = quoted;
    assign o_res.overflow    = ovf;
    assign o_res.bad_hex     = bad;

    // State update once per consumed character
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_string_mode <= 1'b0;
            r_esc         <= ESC_NONE;
            r_hex_first   <= 8'h00;
            r_skip        <= 1'b0;
            r_len         <= 8'd0;
            r_head        <= 32'd0;
        end else if (i_fire) begin
            r_string_mode <= n_string_mode;
            r_esc         <= n_esc;
            r_hex_first   <= n_hex_first;
            r_skip        <= n_skip;
            r_len         <= n_len;
            r_head        <= n_head;
        end
    end

endmodule

@@ rtl/core/source_line_tokenizer_core.sv @@
// Channel | Direction | Transaction
// s_axis  | in        | tdata[7:0] = ch, tlast = line_end
// m_axis  | out       | tdata[7:0] = token_byte, tlast = token_end,
//         |           | tuser[3:0] = {bad_hex, overflow, quoted, byte_valid}
//
// One character per cycle sustained while m_axis accepts results.
// Each character sits in an input register while the tokenizer state is updated,
// and a result, if any, lands in an output register.
// Characters that give no result are consumed without reaching the output.
// m_axis backpressure holds a character in the input register only when it has a
// result and the output register is still full.
// Synchronous active-low reset clears the tokenizer state and both valid flags.
module source_line_tokenizer_core (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_s_axis_tvalid,
    output logic       o_s_axis_tready,
    input  logic [7:0] i_s_axis_tdata,   // [7:0] ch
    input  logic       i_s_axis_tlast,
    output logic       o_m_axis_tvalid,
    input  logic       i_m_axis_tready,
    output logic [7:0] o_m_axis_tdata,   // [7:0] token_byte
    output logic [3:0] o_m_axis_tuser,   // [0] byte_valid, [1] quoted, [2] overflow, [3] bad_hex
    output logic       o_m_axis_tlast
);
    import slt_pkg::*;

    // Input register
    logic       r_in_valid;
    logic [7:0] r_ch;
    logic       r_le;

    // Output register
    logic       r_out_valid;
    t_result    r_out;

    logic       eng_valid;
    t_result    eng_res;
    logic       out_free;
    logic       advance;

    assign out_free        = !r_out_valid || i_m_axis_tready;
    assign advance         = r_in_valid && (!eng_valid || out_free);
    assign o_s_axis_tready = !r_in_valid || advance;

    slt_engine u_engine (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_fire      (advance),
        .i_ch        (r_ch),
        .i_line_end  (r_le),
        .o_res_valid (eng_valid),
        .o_res       (eng_res)
    );

    // Capture incoming transaction
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_s_axis_tready) begin
            r_in_valid <= i_s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_s_axis_tready && i_s_axis_tvalid) begin
            r_ch <= i_s_axis_tdata;
            r_le <= i_s_axis_tlast;
        end
    end

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance && eng_valid) begin
            r_out_valid <= 1'b1;
        end else if (i_m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance && eng_valid) begin
            r_out <= eng_res;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = r_out.token_byte;
    assign o_m_axis_tlast  = r_out.token_end;
    assign o_m_axis_tuser  = {r_out.bad_hex, r_out.overflow, r_out.quoted, r_out.byte_valid};

endmodule
